// ----- design/salc_pkg.sv -----
// Shared types, widths, codes and helpers for the LRU cache tag model.
package salc_pkg;

   // Default geometry of the tag store.
   localparam int MAX_SET_BITS_DEF = 6;
   localparam int MAX_WAYS_DEF     = 8;

   // Field widths of the channels and the register port.
   localparam int MODE_W       = 2;
   localparam int ADDR_W       = 64;
   localparam int STAMP_W      = 32;
   localparam int TOTAL_W      = 32;
   localparam int SET_BITS_W   = 3;
   localparam int BLOCK_BITS_W = 6;
   localparam int WAYS_W       = 4;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 6;

   // Register values after reset.
   localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
   localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
   localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

   // Access kinds carried by a request beat.
   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD   = 2'd0,
      MODE_STORE  = 2'd1,
      MODE_MODIFY = 2'd2,
      MODE_IFETCH = 2'd3
   } mode_type;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SET_BITS    = 2'd0,
      CSR_BLOCK_BITS  = 2'd1,
      CSR_WAYS_IN_USE = 2'd2
   } csr_index_type;

   // One line of the tag store as kept in memory.
   typedef struct packed {
      logic               valid;
      logic [STAMP_W-1:0] stamp;
      logic [ADDR_W-1:0]  tag;
   } line_type;

   // Adds a small increment to a total and sticks at the all-ones value.
   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] value,
                                                  input logic [1:0]         inc);
      logic [TOTAL_W:0] sum;
      sum = {1'b0, value} + (TOTAL_W+1)'(inc);
      return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
   endfunction

endpackage

// ----- design/salc_req_if.sv -----
// Request channel: one access beat with its mode and byte address.
interface salc_req_if import salc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output mode, output address, input ready);
   modport sink   (input valid, input mode, input address, output ready);
endinterface

// ----- design/salc_rsp_if.sv -----
// Response channel: outcome flags and running totals of one access.
interface salc_rsp_if import salc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               was_hit;
   logic               was_miss;
   logic               was_evicted;
   logic               extra_hit;
   logic [TOTAL_W-1:0] hit_total;
   logic [TOTAL_W-1:0] miss_total;
   logic [TOTAL_W-1:0] eviction_total;

   modport source (output valid, output was_hit, output was_miss, output was_evicted,
                   output extra_hit, output hit_total, output miss_total,
                   output eviction_total, input ready);
   modport sink   (input valid, input was_hit, input was_miss, input was_evicted,
                   input extra_hit, input hit_total, input miss_total,
                   input eviction_total, output ready);
endinterface

// ----- design/salc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/set_assoc_lru_cache_model.sv -----
// An accepted data access passes the split state, a scan of its set one way per cycle
// through the single read port, and a write-back state that posts the response. Requests
// are taken only when idle: none is accepted until a data access is written back, which
// waits while the response is held; an instruction fetch is taken and dropped.
// Reset: synchronous; totals, use clock and registers return to their reset values,
// then clearing all 2^MAX_SET_BITS * MAX_WAYS lines (512 by default) blocks requests.
module set_assoc_lru_cache_model import salc_pkg::*; #(
   parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = MAX_WAYS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   salc_req_if.sink               req,
   salc_rsp_if.source             rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);
   localparam int LINE_COUNT = (1 << MAX_SET_BITS) * MAX_WAYS;
   localparam int LINE_W     = LINE_COUNT > 1 ? $clog2(LINE_COUNT) : 1;
   localparam int SET_W      = MAX_SET_BITS > 0 ? MAX_SET_BITS : 1;
   localparam int WAY_CNT_W  = $clog2(MAX_WAYS + 1);
   localparam int WAY_IDX_W  = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_SETUP  = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_UPDATE = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [LINE_W-1:0]        clr_addr_ff, clr_addr_in;
   logic [SET_BITS_W-1:0]    set_bits_ff, set_bits_in;
   logic [BLOCK_BITS_W-1:0]  block_bits_ff, block_bits_in;
   logic [WAYS_W-1:0]        ways_ff, ways_in;
   logic                     modify_ff, modify_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [ADDR_W-1:0]        tag_ff, tag_in;
   logic [LINE_W-1:0]        base_ff, base_in;
   logic [WAY_CNT_W-1:0]     issue_ff, issue_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [WAY_IDX_W-1:0]     cmp_way_ff, cmp_way_in;
   logic                     hit_ff, hit_in;
   logic [WAY_IDX_W-1:0]     hit_way_ff, hit_way_in;
   logic                     free_ff, free_in;
   logic [WAY_IDX_W-1:0]     free_way_ff, free_way_in;
   logic [WAY_IDX_W-1:0]     victim_ff, victim_in;
   logic [STAMP_W-1:0]       best_age_ff, best_age_in;
   logic [STAMP_W-1:0]       use_clock_ff, use_clock_in;
   logic [TOTAL_W-1:0]       hits_ff, hits_in;
   logic [TOTAL_W-1:0]       misses_ff, misses_in;
   logic [TOTAL_W-1:0]       evictions_ff, evictions_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic                     rsp_evict_ff, rsp_evict_in;
   logic                     rsp_extra_ff, rsp_extra_in;

   logic [2:0]               sb_eff;
   logic [WAY_CNT_W-1:0]     ways_eff;
   logic [ADDR_W-1:0]        idx_c;
   logic [SET_W-1:0]         set_c;
   logic [6:0]               tag_shift;
   logic [STAMP_W-1:0]       age_c;
   logic [WAY_IDX_W-1:0]     fill_way;
   line_type                 rd_line;
   logic                     ram_we;
   logic [LINE_W-1:0]        ram_waddr;
   line_type                 ram_wdata;
   logic [LINE_W-1:0]        ram_raddr;

   // Line memory: valid bit, use stamp and tag for every way of every set.
   salc_ram #(
      .WIDTH ($bits(line_type)),
      .DEPTH (LINE_COUNT)
   ) u_lines (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (rd_line)
   );

   // Clamp the geometry registers to what the store can hold.
   always_comb begin
      if (32'(set_bits_ff) > MAX_SET_BITS) begin
         sb_eff = 3'(MAX_SET_BITS);
      end else begin
         sb_eff = set_bits_ff;
      end
      if (32'(ways_ff) > MAX_WAYS) begin
         ways_eff = WAY_CNT_W'(MAX_WAYS);
      end else if (ways_ff == '0) begin
         ways_eff = WAY_CNT_W'(1);
      end else begin
         ways_eff = WAY_CNT_W'(ways_ff);
      end
   end

   // Address split into set index and tag.
   always_comb begin
      idx_c     = addr_ff >> block_bits_ff;
      set_c     = SET_W'(idx_c) & SET_W'((64'(1) << sb_eff) - 64'(1));
      tag_shift = 7'(block_bits_ff) + 7'(sb_eff);
   end

   assign age_c = use_clock_ff - rd_line.stamp;

   // Way written back: the hit way, else the first free way, else the oldest way.
   always_comb begin
      priority if (hit_ff) begin
         fill_way = hit_way_ff;
      end else if (free_ff) begin
         fill_way = free_way_ff;
      end else begin
         fill_way = victim_ff;
      end
   end

   // Sequencer, scan bookkeeping and counters.
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      set_bits_in   = set_bits_ff;
      block_bits_in = block_bits_ff;
      ways_in       = ways_ff;
      modify_in     = modify_ff;
      addr_in       = addr_ff;
      tag_in        = tag_ff;
      base_in       = base_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = 1'b0;
      cmp_way_in    = cmp_way_ff;
      hit_in        = hit_ff;
      hit_way_in    = hit_way_ff;
      free_in       = free_ff;
      free_way_in   = free_way_ff;
      victim_in     = victim_ff;
      best_age_in   = best_age_ff;
      use_clock_in  = use_clock_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      evictions_in  = evictions_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_evict_in  = rsp_evict_ff;
      rsp_extra_in  = rsp_extra_ff;
      ram_we        = 1'b0;
      ram_waddr     = clr_addr_ff;
      ram_wdata     = '0;
      ram_raddr     = base_ff + LINE_W'(issue_ff);

      // Register writes are taken in any state.
      if (csr_we) begin
         unique case (csr_index)
            CSR_SET_BITS:    set_bits_in   = csr_wdata[SET_BITS_W-1:0];
            CSR_BLOCK_BITS:  block_bits_in = csr_wdata[BLOCK_BITS_W-1:0];
            CSR_WAYS_IN_USE: ways_in       = csr_wdata[WAYS_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         // Invalidate every line once after reset.
         ST_CLEAR: begin
            ram_we      = 1'b1;
            clr_addr_in = clr_addr_ff + LINE_W'(1);
            if (clr_addr_ff == LINE_W'(LINE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // Take a request beat; instruction fetches are dropped here.
         ST_IDLE: begin
            if (req.valid) begin
               addr_in   = req.address;
               modify_in = (req.mode == MODE_MODIFY);
               if (req.mode != MODE_IFETCH) begin
                  state_in = ST_SETUP;
               end
            end
         end

         // Split the address and reset the scan state.
         ST_SETUP: begin
            base_in     = LINE_W'(32'(set_c) * 32'(MAX_WAYS));
            tag_in      = (tag_shift >= 7'd64) ? '0 : (addr_ff >> tag_shift[5:0]);
            issue_in    = '0;
            hit_in      = 1'b0;
            free_in     = 1'b0;
            victim_in   = '0;
            best_age_in = '0;
            state_in    = ST_SCAN;
         end

         // Read one way per cycle and check the way read in the cycle before.
         ST_SCAN: begin
            if (issue_ff != ways_eff) begin
               issue_in   = issue_ff + WAY_CNT_W'(1);
               cmp_vld_in = 1'b1;
               cmp_way_in = WAY_IDX_W'(issue_ff);
            end else begin
               state_in = ST_UPDATE;
            end
            if (cmp_vld_ff && !hit_ff) begin
               priority if (rd_line.valid && rd_line.tag == tag_ff) begin
                  hit_in     = 1'b1;
                  hit_way_in = cmp_way_ff;
               end else if (!rd_line.valid) begin
                  if (!free_ff) begin
                     free_in     = 1'b1;
                     free_way_in = cmp_way_ff;
                  end
               end else begin
                  if (cmp_way_ff == '0 || age_c > best_age_ff) begin
                     best_age_in = age_c;
                     victim_in   = cmp_way_ff;
                  end
               end
            end
         end

         // Write the line back and post the response once the output is free.
         ST_UPDATE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               ram_we          = 1'b1;
               ram_waddr       = base_ff + LINE_W'(fill_way);
               ram_wdata.valid = 1'b1;
               ram_wdata.stamp = use_clock_ff + STAMP_W'(modify_ff);
               ram_wdata.tag   = tag_ff;
               use_clock_in    = use_clock_ff + STAMP_W'(1) + STAMP_W'(modify_ff);
               hits_in         = sat_add(hits_ff, {1'b0, hit_ff} + {1'b0, modify_ff});
               misses_in       = sat_add(misses_ff, {1'b0, !hit_ff});
               evictions_in    = sat_add(evictions_ff, {1'b0, !hit_ff && !free_ff});
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = hit_ff;
               rsp_evict_in    = !hit_ff && !free_ff;
               rsp_extra_in    = modify_ff;
               state_in        = ST_IDLE;
            end
         end

         default: state_in = ST_CLEAR;
      endcase
   end

   // Control state and totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         set_bits_ff   <= SET_BITS_RST;
         block_bits_ff <= BLOCK_BITS_RST;
         ways_ff       <= WAYS_RST;
         cmp_vld_ff    <= 1'b0;
         use_clock_ff  <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         evictions_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         set_bits_ff   <= set_bits_in;
         block_bits_ff <= block_bits_in;
         ways_ff       <= ways_in;
         cmp_vld_ff    <= cmp_vld_in;
         use_clock_ff  <= use_clock_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         evictions_ff  <= evictions_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Access payload and scan results.
   always_ff @(posedge clock) begin
      modify_ff   <= modify_in;
      addr_ff     <= addr_in;
      tag_ff      <= tag_in;
      base_ff     <= base_in;
      issue_ff    <= issue_in;
      cmp_way_ff  <= cmp_way_in;
      hit_ff      <= hit_in;
      hit_way_ff  <= hit_way_in;
      free_ff     <= free_in;
      free_way_ff <= free_way_in;
      victim_ff   <= victim_in;
      best_age_ff <= best_age_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_evict_ff <= rsp_evict_in;
      rsp_extra_ff <= rsp_extra_in;
   end

   // Channel outputs; the totals only move when a response beat is loaded.
   assign req.ready          = (state_ff == ST_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.was_hit        = rsp_hit_ff;
   assign rsp.was_miss       = !rsp_hit_ff;
   assign rsp.was_evicted    = rsp_evict_ff;
   assign rsp.extra_hit      = rsp_extra_ff;
   assign rsp.hit_total      = hits_ff;
   assign rsp.miss_total     = misses_ff;
   assign rsp.eviction_total = evictions_ff;
endmodule
